// ----- rtl/sfir_pkg.sv -----
`default_nettype none

package sfir_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 16;
   localparam int DIVISOR_W = 15;
   localparam int TAPS_W    = 3;
   localparam int FILT_W    = 17;
   localparam int NUM_COEFS = 5;
   localparam int PROD_W    = COEF_W + SAMPLE_W + 1;
   localparam int SUM_W     = PROD_W + 3;
   localparam int MAG_W     = SUM_W - 1;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 3;

   localparam logic [MAG_W-1:0] SIGNED_MAX   = MAG_W'(32767);
   localparam logic [MAG_W-1:0] SIGNED_MIN_M = MAG_W'(32768);
   localparam logic [MAG_W-1:0] UNSIGNED_MAX = MAG_W'(65535);

   localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COEF_0        = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_COEF_1        = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COEF_2        = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COEF_3        = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_COEF_4        = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_DIVISOR       = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SIGNED_OUTPUT = 3'd7;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                first_of_line;
      logic                last_of_line;
   } req_word_type;

   typedef struct packed {
      logic signed [FILT_W-1:0] filtered;
      logic                     clipped;
      logic                     end_of_line;
   } rsp_word_type;

   typedef struct packed {
      logic shift;
      logic clear;
      logic load_prod;
      logic shift_prod;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DIV_START,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/scaled_fir_line_filter.sv -----
// Line-camera FIR filter with up to MAX_TAPS signed taps and a divisor.
// Input words arrive on req_valid/req_ready with a sample and line markers;
// results leave on rsp_valid/rsp_ready. Coefficient 0 weights the newest
// sample. A word that does not yet fill the window of the current line
// gives no result and leaves req_ready high. A word that gives a result
// holds req_ready low while the filter steps through its states: a multiply
// state, an accumulate state in which the products shift down the cell row
// into the accumulator, a divider start state, a divider that works out one
// quotient bit per cycle over the 35-bit sum magnitude, the divider done
// flag, and the load of the output register; no new word is taken before
// that load.
// The result then sits in the output register until taken; the next word
// can be accepted meanwhile, and a second result waits in the final state,
// stretching the stall, while the receiver holds off. Registers sit on an
// APB port at byte address 4*i. Reset restores the register defaults,
// clears the sample window and the line fill count, and empties the output
// register.
`default_nettype none

module scaled_fir_line_filter
   import sfir_pkg::*;
#(
   parameter int MAX_TAPS = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_word_type        req_word,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_word_type        rsp_word,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   localparam int CNT_W = $clog2(MAX_TAPS + 1);

   logic [TAPS_W-1:0]        tap_count_ff;
   logic signed [COEF_W-1:0] coef_ff [NUM_COEFS];
   logic [DIVISOR_W-1:0]     divisor_ff;
   logic                     signed_output_ff;

   state_type                state_ff;
   state_type                state_in;
   logic [TAPS_W-1:0]        fill_ff;
   logic [TAPS_W-1:0]        fill_in;
   logic [CNT_W-1:0]         cnt_ff;
   logic signed [SUM_W-1:0]  acc_ff;
   logic                     neg_ff;
   logic                     last_ff;
   logic                     rsp_valid_ff;
   rsp_word_type             rsp_word_ff;

   logic                     accept;
   logic                     csr_write;
   logic [TAPS_W-1:0]        taps_use;
   logic                     produce;
   logic                     out_free;
   logic                     load_prod;
   logic                     shift_prod;
   logic                     div_start;
   logic                     load_out;
   logic                     div_busy;
   logic                     div_done;
   logic [MAG_W-1:0]         quotient;
   logic [MAG_W-1:0]         dividend;
   logic signed [FILT_W-1:0] sat_value;
   logic                     sat_clip;
   cell_ctl_type             ctl_head;
   cell_ctl_type             ctl_tail;

   logic [SAMPLE_W-1:0]      sample_chain [MAX_TAPS];
   logic signed [PROD_W-1:0] prod_chain [MAX_TAPS+1];

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff     <= TAPS_W'(3);
         coef_ff[0]       <= COEF_W'(1);
         coef_ff[1]       <= COEF_W'(2);
         coef_ff[2]       <= COEF_W'(1);
         coef_ff[3]       <= '0;
         coef_ff[4]       <= '0;
         divisor_ff       <= DIVISOR_W'(4);
         signed_output_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (paddr[ADDR_W-1:2])
            REG_TAP_COUNT:     tap_count_ff     <= pwdata[TAPS_W-1:0];
            REG_COEF_0:        coef_ff[0]       <= pwdata[COEF_W-1:0];
            REG_COEF_1:        coef_ff[1]       <= pwdata[COEF_W-1:0];
            REG_COEF_2:        coef_ff[2]       <= pwdata[COEF_W-1:0];
            REG_COEF_3:        coef_ff[3]       <= pwdata[COEF_W-1:0];
            REG_COEF_4:        coef_ff[4]       <= pwdata[COEF_W-1:0];
            REG_DIVISOR:       divisor_ff       <= pwdata[DIVISOR_W-1:0];
            REG_SIGNED_OUTPUT: signed_output_ff <= pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[ADDR_W-1:2])
         REG_TAP_COUNT:     prdata = DATA_W'(tap_count_ff);
         REG_COEF_0:        prdata = DATA_W'($unsigned(coef_ff[0]));
         REG_COEF_1:        prdata = DATA_W'($unsigned(coef_ff[1]));
         REG_COEF_2:        prdata = DATA_W'($unsigned(coef_ff[2]));
         REG_COEF_3:        prdata = DATA_W'($unsigned(coef_ff[3]));
         REG_COEF_4:        prdata = DATA_W'($unsigned(coef_ff[4]));
         REG_DIVISOR:       prdata = DATA_W'(divisor_ff);
         REG_SIGNED_OUTPUT: prdata = DATA_W'(signed_output_ff);
      endcase
   end

   always_comb begin
      priority if (tap_count_ff == '0) begin
         taps_use = TAPS_W'(1);
      end else if (tap_count_ff > TAPS_W'(MAX_TAPS)) begin
         taps_use = TAPS_W'(MAX_TAPS);
      end else begin
         taps_use = tap_count_ff;
      end
   end

   always_comb begin
      priority if (req_word.first_of_line) begin
         fill_in = TAPS_W'(1);
      end else if (fill_ff < TAPS_W'(MAX_TAPS)) begin
         fill_in = fill_ff + 1'b1;
      end else begin
         fill_in = fill_ff;
      end
   end

   assign produce = (fill_in >= taps_use);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && produce) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            if (cnt_ff == CNT_W'(MAX_TAPS - 1)) state_in = ST_DIV_START;
         end
         ST_DIV_START: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      load_prod  = 1'b0;
      shift_prod = 1'b0;
      div_start  = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE:      ;
         ST_MUL:       load_prod  = 1'b1;
         ST_ACC:       shift_prod = 1'b1;
         ST_DIV_START: div_start  = 1'b1;
         ST_DIV:       ;
         ST_DONE:      load_out   = out_free;
         default:      ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign ctl_head = '{shift: accept, clear: 1'b0, load_prod: load_prod,
                       shift_prod: shift_prod};
   assign ctl_tail = '{shift: accept, clear: req_word.first_of_line,
                       load_prod: load_prod, shift_prod: shift_prod};

   assign prod_chain[MAX_TAPS] = '0;

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      if (k == 0) begin : g_head
         sfir_tap_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl_head),
            .tap_enable (1'b1),
            .coef       (coef_ff[k]),
            .sample_in  (req_word.sample),
            .sample_out (sample_chain[k]),
            .prod_in    (prod_chain[k+1]),
            .prod_out   (prod_chain[k])
         );
      end else begin : g_tail
         sfir_tap_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl_tail),
            .tap_enable (taps_use > TAPS_W'(k)),
            .coef       (coef_ff[k]),
            .sample_in  (sample_chain[k-1]),
            .sample_out (sample_chain[k]),
            .prod_in    (prod_chain[k+1]),
            .prod_out   (prod_chain[k])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= req_word.last_of_line;
      end
      if (load_prod) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else if (shift_prod) begin
         acc_ff <= acc_ff + SUM_W'(prod_chain[0]);
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (div_start) begin
         neg_ff <= acc_ff[SUM_W-1];
      end
   end

   assign dividend = acc_ff[SUM_W-1] ? MAG_W'(-acc_ff) : MAG_W'(acc_ff);

   sfir_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      sat_value = '0;
      sat_clip  = 1'b0;
      priority if (neg_ff && quotient != '0) begin
         if (!signed_output_ff) begin
            sat_clip = 1'b1;
         end else if (quotient > SIGNED_MIN_M) begin
            sat_value = -FILT_W'(SIGNED_MIN_M);
            sat_clip  = 1'b1;
         end else begin
            sat_value = -FILT_W'(quotient);
         end
      end else if (neg_ff) begin
         sat_value = '0;
      end else if (signed_output_ff && quotient > SIGNED_MAX) begin
         sat_value = FILT_W'(SIGNED_MAX);
         sat_clip  = 1'b1;
      end else if (!signed_output_ff && quotient > UNSIGNED_MAX) begin
         sat_value = FILT_W'(UNSIGNED_MAX);
         sat_clip  = 1'b1;
      end else begin
         sat_value = FILT_W'(quotient);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_word_ff <= '{filtered: sat_value, clipped: sat_clip, end_of_line: last_ff};
      end
   end

`ifndef NO_ASSERTIONS
   a_div_start_idle : assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_clip_at_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.clipped |->
         (rsp_word.filtered == 17'sd0 || rsp_word.filtered == 17'sd65535 ||
          rsp_word.filtered == 17'sd32767 || rsp_word.filtered == -17'sd32768))
      else $error("clipped result not at a range bound");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      accept |=> fill_ff <= TAPS_W'(MAX_TAPS) && fill_ff != '0)
      else $error("line fill count out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/sfir_tap_cell.sv -----
`default_nettype none

module sfir_tap_cell
   import sfir_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctl_type              ctl,
   input  logic                      tap_enable,
   input  logic signed [COEF_W-1:0]  coef,
   input  logic [SAMPLE_W-1:0]       sample_in,
   output logic [SAMPLE_W-1:0]       sample_out,
   input  logic signed [PROD_W-1:0]  prod_in,
   output logic signed [PROD_W-1:0]  prod_out
);

   logic [SAMPLE_W-1:0]      sample_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] product;

   assign product    = coef * $signed({1'b0, sample_ff});
   assign sample_out = sample_ff;
   assign prod_out   = prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (ctl.shift) begin
         sample_ff <= ctl.clear ? '0 : sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         prod_ff <= tap_enable ? product : '0;
      end else if (ctl.shift_prod) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sfir_divider.sv -----
`default_nettype none

module sfir_divider
   import sfir_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MAG_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 busy,
   output logic                 done,
   output logic [MAG_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(MAG_W + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [MAG_W-1:0]     quo_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] den_ff;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   assign trial    = {rem_ff, quo_ff[MAG_W-1]};
   assign fits     = trial >= {1'b0, den_ff};
   assign diff     = trial - {1'b0, den_ff};
   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(MAG_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= (divisor == '0) ? DIVISOR_W'(1) : divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[MAG_W-2:0], fits};
         rem_ff <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- bench/scaled_fir_line_filter_tb.sv -----
`default_nettype none

module scaled_fir_line_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfir_pkg::*;

   localparam int MAX_TAPS     = 5;
   localparam int SETTLE_CYCLES = 3 + MAX_TAPS + 35 + 20;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 600000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_word_type        req_word = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_word_type        rsp_word;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   scaled_fir_line_filter #(
      .MAX_TAPS(MAX_TAPS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #5 clock = ~clock;

   // shadow of the register file
   logic [TAPS_W-1:0]           tap_cfg = 3'd3;
   logic signed [COEF_W-1:0]    coef_cfg [NUM_COEFS] = '{16'sd1, 16'sd2, 16'sd1, 16'sd0, 16'sd0};
   logic [DIVISOR_W-1:0]        div_cfg = 15'd4;
   logic                        signed_cfg = 1'b0;

   logic [SAMPLE_W-1:0]         window_q [4] = '{default: '0};
   int                          fill_seen = 0;

   req_word_type                sample_backlog [$];
   rsp_word_type                filtered_due [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asked = 0;
   int hold_given = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int words_sent = 0;
   int results_checked = 0;
   int settings_applied = 0;

   function automatic void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
   endfunction

   function automatic void filter_sample(req_word_type w);
      longint       acc;
      longint       dv;
      longint       quo;
      longint       lo;
      longint       hi;
      int           taps;
      rsp_word_type r;
      taps = (tap_cfg == 0) ? 1 : ((tap_cfg > MAX_TAPS) ? MAX_TAPS : int'(tap_cfg));
      if (w.first_of_line) begin
         for (int k = 0; k < 4; k++) window_q[k] = '0;
         fill_seen = 0;
      end
      if (fill_seen < MAX_TAPS) fill_seen++;
      if (fill_seen >= taps) begin
         acc = longint'(coef_cfg[0]) * longint'(w.sample);
         for (int k = 1; k < taps; k++) acc += longint'(coef_cfg[k]) * longint'(window_q[k-1]);
         dv = (div_cfg == 0) ? 64'sd1 : longint'(div_cfg);
         quo = acc / dv;
         lo = signed_cfg ? -64'sd32768 : 64'sd0;
         hi = signed_cfg ? 64'sd32767 : 64'sd65535;
         r.clipped = 1'b0;
         if (quo < lo) begin
            quo = lo;
            r.clipped = 1'b1;
         end
         if (quo > hi) begin
            quo = hi;
            r.clipped = 1'b1;
         end
         r.filtered = quo[FILT_W-1:0];
         r.end_of_line = w.last_of_line;
         filtered_due.push_back(r);
      end
      for (int k = 3; k > 0; k--) window_q[k] = window_q[k-1];
      window_q[0] = w.sample;
   endfunction

   function automatic void push_sample(logic [SAMPLE_W-1:0] s, logic f, logic l);
      sample_backlog.push_back('{sample: s, first_of_line: f, last_of_line: l});
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_TAP_COUNT:     tap_cfg = value[TAPS_W-1:0];
         REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4:
            coef_cfg[idx - REG_COEF_0] = value[COEF_W-1:0];
         REG_DIVISOR:       div_cfg = value[DIVISOR_W-1:0];
         REG_SIGNED_OUTPUT: signed_cfg = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_setting(logic [TAPS_W-1:0] taps, logic [COEF_W-1:0] c0,
                                logic [COEF_W-1:0] c1, logic [COEF_W-1:0] c2,
                                logic [COEF_W-1:0] c3, logic [COEF_W-1:0] c4,
                                logic [DIVISOR_W-1:0] dv, logic sg);
      csr_write(REG_TAP_COUNT, DATA_W'(taps));
      csr_write(REG_COEF_0, DATA_W'(c0));
      csr_write(REG_COEF_1, DATA_W'(c1));
      csr_write(REG_COEF_2, DATA_W'(c2));
      csr_write(REG_COEF_3, DATA_W'(c3));
      csr_write(REG_COEF_4, DATA_W'(c4));
      csr_write(REG_DIVISOR, DATA_W'(dv));
      csr_write(REG_SIGNED_OUTPUT, DATA_W'(sg));
      settings_applied++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (sample_backlog.size() != 0 || req_valid || filtered_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            filter_sample(req_word);
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_word  <= sample_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_asked != hold_given) begin
         hold_left  <= HOLD_CYCLES;
         hold_given <= hold_given + 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : rsp_side
      rsp_word_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (filtered_due.size() == 0) begin
               note_mismatch($sformatf("word with none pending: filtered %0d clipped %0b eol %0b",
                                       rsp_word.filtered, rsp_word.clipped,
                                       rsp_word.end_of_line));
            end else begin
               due = filtered_due.pop_front();
               results_checked++;
               if (rsp_word.filtered !== due.filtered || rsp_word.clipped !== due.clipped ||
                   rsp_word.end_of_line !== due.end_of_line)
                  note_mismatch($sformatf(
                     "filtered %0d/%0d clipped %0b/%0b eol %0b/%0b (expected/actual)",
                     due.filtered, rsp_word.filtered, due.clipped, rsp_word.clipped,
                     due.end_of_line, rsp_word.end_of_line));
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due", cycle_count,
                  filtered_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int                  phase;
      int                  seg;
      int                  k;
      int                  n;
      int                  r;
      int                  queued;
      logic [COEF_W-1:0]   cf [NUM_COEFS];
      logic [DIVISOR_W-1:0] dv;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults, no line start yet
      push_sample(16'd0, 1'b0, 1'b0);
      push_sample(16'hFFFF, 1'b0, 1'b0);
      push_sample(16'hFFFF, 1'b0, 1'b1);
      push_sample(16'd12345, 1'b1, 1'b0);
      push_sample(16'd7, 1'b0, 1'b0);
      push_sample(16'd2, 1'b0, 1'b1);
      wait_idle();

      apply_setting(3'd5, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 15'd1, 1'b0);
      for (k = 0; k < 5; k++) push_sample(16'hFFFF, k == 0, k == 4);
      wait_idle();

      apply_setting(3'd5, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'd1, 1'b1);
      for (k = 0; k < 5; k++) push_sample(16'hFFFF, k == 0, k == 4);
      wait_idle();

      // zero tap count and zero divisor
      apply_setting(3'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0, 1'b1);
      push_sample(16'hFFFF, 1'b1, 1'b0);
      push_sample(16'd1, 1'b0, 1'b0);
      push_sample(16'h8000, 1'b0, 1'b1);
      wait_idle();

      apply_setting(3'd7, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 15'h7FFF, 1'b0);
      for (k = 0; k < 5; k++) push_sample(16'hFFFF, k == 0, k == 4);
      wait_idle();

      // raise tap count in the middle of a line
      apply_setting(3'd2, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 15'd1, 1'b0);
      push_sample(16'd100, 1'b1, 1'b0);
      push_sample(16'd200, 1'b0, 1'b0);
      wait_idle();
      csr_write(REG_TAP_COUNT, DATA_W'(4));
      push_sample(16'd300, 1'b0, 1'b0);
      push_sample(16'd400, 1'b0, 1'b1);

      for (phase = 0; phase < 3; phase++) begin
         wait_idle();
         send_idle_pct = (phase == 0) ? 37 : ((phase == 1) ? 67 : 0);
         recv_idle_pct = (phase == 0) ? 67 : ((phase == 1) ? 37 : 0);
         for (seg = 0; seg < 4; seg++) begin
            wait_idle();
            for (k = 0; k < NUM_COEFS; k++) begin
               r = $urandom_range(0, 9);
               if (r < 5) cf[k] = 16'($urandom_range(0, 16)) - 16'd8;
               else if (r < 7) cf[k] = r[0] ? 16'h8000 : 16'h7FFF;
               else cf[k] = 16'($urandom_range(0, 65535));
            end
            r = $urandom_range(0, 9);
            if (r < 4) dv = 15'($urandom_range(0, 8));
            else if (r < 6) dv = (r == 4) ? 15'd1 : 15'h7FFF;
            else dv = 15'($urandom_range(0, 32767));
            apply_setting(3'($urandom_range(0, 7)), cf[0], cf[1], cf[2], cf[3], cf[4], dv,
                          1'($urandom_range(0, 1)));
            // stall the receiver while words keep coming
            if (phase == 0 && seg == 1) hold_asked++;
            queued = 0;
            while (queued < 96) begin
               if ($urandom_range(0, 9) < 8) begin
                  n = $urandom_range(1, 24);
                  for (k = 0; k < n; k++) push_sample(pick_sample(), k == 0, k == n - 1);
               end else begin
                  n = $urandom_range(1, 6);
                  for (k = 0; k < n; k++)
                     push_sample(pick_sample(), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
               end
               queued += n;
            end
         end
      end

      wait_idle();
      if (filtered_due.size() != 0)
         note_mismatch($sformatf("%0d filtered words never arrived", filtered_due.size()));
      $display("sent %0d sample words over %0d register settings, checked %0d filtered words",
               words_sent, settings_applied, results_checked);
      $display("mismatching words: %0d", mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/sfir_pkg.sv
rtl/sfir_tap_cell.sv
rtl/sfir_divider.sv
rtl/scaled_fir_line_filter.sv
bench/scaled_fir_line_filter_tb.sv
